// ===== design/utxrf_pkg.sv =====
// Shared types and constants for the UART transmitter with ring FIFO.
// No dependencies; imported by the top level.
`timescale 1ns / 1ps

package utxrf_pkg;

	// Default number of ring slots; the ring holds one byte less.
	localparam int QUEUE_DEPTH_DEF = 16;

	localparam int DATA_BITS = 8;
	localparam int RES_W     = 8;

	// Input kind carried on tuser
	localparam logic CMD_ENQUEUE = 1'b0;
	localparam logic CMD_TICK    = 1'b1;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_START,
		PH_DATA,
		PH_STOP
	} phase_t;

endpackage

// ===== design/utxrf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies; used for the transmit ring store.
`timescale 1ns / 1ps

module utxrf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== design/uart_tx_with_ring_fifo.sv =====
// Top level: 8N1 serial transmitter fed by a ring FIFO held in a RAM.
// Depends on utxrf_pkg and utxrf_ram.
`timescale 1ns / 1ps

// Each transfer on the input stream is either a byte to queue (tuser = 0) or one
// bit-time tick (tuser = 1), and yields exactly one status transfer on the output
// stream: the line level, busy, and whether the byte was dropped (ring full in the
// data or stop phase) or the oldest byte was discarded (ring full otherwise). The
// ring has QUEUE_DEPTH slots and holds QUEUE_DEPTH-1 bytes. One item is taken every
// clock cycle while the skid entry is empty; its status is registered. The ring RAM
// is read ahead at the next read pointer, bypassed when the same cycle writes that
// slot, so a tick in the data phase finds its byte ready. A two-entry output stage
// keeps the input flowing while one status waits. No clearing pass after reset.
module uart_tx_with_ring_fifo
	import utxrf_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	input  logic [7:0]       s_axis_tdata,  // [7:0] data_byte
	input  logic             s_axis_tuser,  // [0] command
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	output logic [RES_W-1:0] m_axis_tdata   // [0] tx_line, [1] busy_res,
	                                        // [2] byte_dropped, [3] oldest_discarded
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		ptr_next = (p == PTR_LAST) ? '0 : p + PTR_W'(1);
	endfunction

	logic [PTR_W-1:0] rp_q, wp_q, rp_d, wp_d;
	phase_t           phase_q, phase_d;
	logic [3:0]       bitpos_q, bitpos_d;
	logic             active_q, active_d;
	logic             line_q, line_d;
	logic             dropped, discarded, busy;
	logic             ram_we;
	logic [7:0]       ram_rdata, cur_byte;
	logic             fwd_q;
	logic [7:0]       fwd_byte_q;
	logic             accept;
	logic [RES_W-1:0] res_word;

	logic             out_valid_q, skid_valid_q;
	logic [RES_W-1:0] out_data_q, skid_data_q;

	assign accept   = s_axis_tvalid && s_axis_tready;
	assign cur_byte = fwd_q ? fwd_byte_q : ram_rdata;

	always_comb begin
		rp_d      = rp_q;
		wp_d      = wp_q;
		phase_d   = phase_q;
		bitpos_d  = bitpos_q;
		active_d  = active_q;
		line_d    = line_q;
		dropped   = 1'b0;
		discarded = 1'b0;
		ram_we    = 1'b0;
		if (accept) begin
			unique case (s_axis_tuser)
				CMD_ENQUEUE: begin
					if (rp_q == ptr_next(wp_q)) begin
						if (phase_q == PH_DATA || phase_q == PH_STOP) begin
							dropped = 1'b1;
						end else begin
							rp_d      = ptr_next(rp_q);
							discarded = 1'b1;
						end
					end
					if (!dropped) begin
						ram_we   = 1'b1;
						wp_d     = ptr_next(wp_q);
						active_d = 1'b1;
					end
				end
				CMD_TICK: begin
					if (active_q) begin
						unique case (phase_q)
							PH_IDLE: begin
								phase_d = PH_START;
							end
							PH_START: begin
								line_d   = 1'b0;
								bitpos_d = '0;
								phase_d  = PH_DATA;
							end
							PH_DATA: begin
								line_d   = cur_byte[bitpos_q[2:0]];
								bitpos_d = bitpos_q + 4'd1;
								if (bitpos_d >= 4'(DATA_BITS)) begin
									phase_d = PH_STOP;
								end
							end
							PH_STOP: begin
								line_d = 1'b1;
								rp_d   = ptr_next(rp_q);
								// dequeue; stop when the ring runs dry
								if (rp_d == wp_q) begin
									phase_d  = PH_IDLE;
									active_d = 1'b0;
								end else begin
									phase_d = PH_START;
								end
							end
							default: begin
								phase_d = PH_IDLE;
							end
						endcase
					end
				end
				default: begin
					line_d = line_q;
				end
			endcase
		end
		busy     = active_d || (rp_d != wp_d);
		res_word = {{(RES_W - 4){1'b0}}, discarded, dropped, busy, line_d};
	end

	// Registered read, ahead at the pointer the next item will see
	utxrf_ram #(
		.WIDTH(8),
		.DEPTH(QUEUE_DEPTH)
	) u_ring (
		.clk  (clk),
		.we   (ram_we),
		.waddr(wp_q),
		.wdata(s_axis_tdata),
		.raddr(rp_d),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rp_q     <= '0;
			wp_q     <= '0;
			phase_q  <= PH_IDLE;
			bitpos_q <= '0;
			active_q <= 1'b0;
			line_q   <= 1'b1;
			fwd_q    <= 1'b0;
		end else begin
			rp_q     <= rp_d;
			wp_q     <= wp_d;
			phase_q  <= phase_d;
			bitpos_q <= bitpos_d;
			active_q <= active_d;
			line_q   <= line_d;
			// bypass the RAM when this cycle writes the slot being read
			fwd_q    <= ram_we && (wp_q == rp_d);
		end
	end

	always_ff @(posedge clk) begin
		if (ram_we) begin
			fwd_byte_q <= s_axis_tdata;
		end
	end

	// Output register plus skid entry
	assign s_axis_tready = !skid_valid_q;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (!out_valid_q || m_axis_tready) begin
				if (skid_valid_q) begin
					out_valid_q  <= 1'b1;
					skid_valid_q <= 1'b0;
				end else begin
					out_valid_q <= accept;
				end
			end else if (accept) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || m_axis_tready) begin
			if (skid_valid_q) begin
				out_data_q <= skid_data_q;
			end else if (accept) begin
				out_data_q <= res_word;
			end
		end else if (accept) begin
			skid_data_q <= res_word;
		end
	end

endmodule

// ===== tb/utxrf_checker.sv =====
// Scoreboard for the UART transmitter with ring FIFO: watches both streams,
// predicts the status word of each input transfer and compares. Uses utxrf_pkg.
`timescale 1ns / 1ps

module utxrf_checker
	import utxrf_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_axis_tvalid,
	input  logic             s_axis_tready,
	input  logic [7:0]       s_axis_tdata,  // [7:0] data_byte
	input  logic             s_axis_tuser,  // [0] command
	input  logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	input  logic [RES_W-1:0] m_axis_tdata,  // [0] tx_line, [1] busy_res,
	                                        // [2] byte_dropped, [3] oldest_discarded
	output int               mismatches,
	output int               outstanding
);

	typedef struct packed {
		logic oldest_discarded;
		logic byte_dropped;
		logic busy;
		logic tx_line;
	} line_status_t;

	// Shadow of the transmitter
	logic [7:0]   ring [QUEUE_DEPTH];
	int           rd_ptr;
	int           wr_ptr;
	phase_t       phase;
	logic [3:0]   bit_pos;
	logic         sending;
	logic         line_lvl;

	line_status_t status_q[$];
	int           err_count = 0;

	assign mismatches = err_count;

	function automatic int ring_next(input int p);
		return (p == QUEUE_DEPTH - 1) ? 0 : p + 1;
	endfunction

	// Apply one input item to the shadow state and return the status it yields.
	function automatic line_status_t advance_line(input logic cmd, input logic [7:0] b);
		line_status_t st;
		logic [7:0]   cur;
		st = '0;
		if (cmd == CMD_ENQUEUE) begin
			if (rd_ptr == ring_next(wr_ptr)) begin
				// full: drop once the start bit is out, else discard the oldest
				if (phase == PH_DATA || phase == PH_STOP) begin
					st.byte_dropped = 1'b1;
				end else begin
					rd_ptr = ring_next(rd_ptr);
					st.oldest_discarded = 1'b1;
				end
			end
			if (!st.byte_dropped) begin
				ring[wr_ptr] = b;
				wr_ptr = ring_next(wr_ptr);
				sending = 1'b1;
			end
		end else if (sending) begin
			case (phase)
				PH_IDLE: begin
					phase = PH_START;
				end
				PH_START: begin
					line_lvl = 1'b0;
					bit_pos = 4'd0;
					phase = PH_DATA;
				end
				PH_DATA: begin
					cur = ring[rd_ptr];
					line_lvl = cur[bit_pos[2:0]];
					bit_pos = bit_pos + 4'd1;
					if (bit_pos >= 4'd8) begin
						phase = PH_STOP;
					end
				end
				default: begin
					line_lvl = 1'b1;
					rd_ptr = ring_next(rd_ptr);
					if (rd_ptr == wr_ptr) begin
						phase = PH_IDLE;
						sending = 1'b0;
					end else begin
						phase = PH_START;
					end
				end
			endcase
		end
		st.tx_line = line_lvl;
		st.busy = sending || (rd_ptr != wr_ptr);
		return st;
	endfunction

	task automatic report_mismatch(input string what, input int want_v, input int got_v);
		$display("%0t ns: %s mismatch, expected %0d got %0d", $time, what, want_v, got_v);
		err_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin : track
		line_status_t want;
		if (!arst_n) begin
			rd_ptr = 0;
			wr_ptr = 0;
			phase = PH_IDLE;
			bit_pos = 4'd0;
			sending = 1'b0;
			line_lvl = 1'b1;
			status_q.delete();
			outstanding <= 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				status_q.push_back(advance_line(s_axis_tuser, s_axis_tdata));
			end
			if (m_axis_tvalid && m_axis_tready) begin
				if (status_q.size() == 0) begin
					report_mismatch("unexpected status transfer", 0, 1);
				end else begin
					want = status_q.pop_front();
					if (m_axis_tdata[0] !== want.tx_line)
						report_mismatch("tx_line", int'(want.tx_line),
							int'(m_axis_tdata[0]));
					if (m_axis_tdata[1] !== want.busy)
						report_mismatch("busy_res", int'(want.busy),
							int'(m_axis_tdata[1]));
					if (m_axis_tdata[2] !== want.byte_dropped)
						report_mismatch("byte_dropped", int'(want.byte_dropped),
							int'(m_axis_tdata[2]));
					if (m_axis_tdata[3] !== want.oldest_discarded)
						report_mismatch("oldest_discarded", int'(want.oldest_discarded),
							int'(m_axis_tdata[3]));
					if (m_axis_tdata[RES_W-1:4] !== '0)
						report_mismatch("padding bits", 0,
							int'(m_axis_tdata[RES_W-1:4]));
				end
			end
			outstanding <= status_q.size();
		end
	end

endmodule

// ===== tb/tb_uart_tx_with_ring_fifo.sv =====
// Testbench top for uart_tx_with_ring_fifo: clock, reset, byte and tick stimulus,
// output back-pressure and verdict. Depends on utxrf_pkg and utxrf_checker.
`timescale 1ns / 1ps

module tb_uart_tx_with_ring_fifo;
	import utxrf_pkg::*;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             s_axis_tvalid;
	logic             s_axis_tready;
	logic [7:0]       s_axis_tdata;   // [7:0] data_byte
	logic             s_axis_tuser;   // [0] command
	logic             m_axis_tvalid;
	logic             m_axis_tready;
	logic [RES_W-1:0] m_axis_tdata;   // [0] tx_line, [1] busy_res,
	                                  // [2] byte_dropped, [3] oldest_discarded

	int   mismatches;
	int   outstanding;
	int   items_sent = 0;
	logic no_gaps = 1'b0;     // both sides run without idling while set
	logic hold_req = 1'b0;    // ask the receiver for one long hold-off

	always #1 clk = ~clk;

	uart_tx_with_ring_fifo #(
		.QUEUE_DEPTH(QUEUE_DEPTH_DEF)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	utxrf_checker #(
		.QUEUE_DEPTH(QUEUE_DEPTH_DEF)
	) u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.mismatches   (mismatches),
		.outstanding  (outstanding)
	);

	// Offer one item after a random gap and hold it until the transfer.
	task automatic send_item(input logic cmd, input logic [7:0] b);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= cmd;
		s_axis_tdata <= b;
		do @(posedge clk); while (!s_axis_tready);
		items_sent++;
	endtask

	task automatic send_byte(input logic [7:0] b);
		send_item(CMD_ENQUEUE, b);
	endtask

	task automatic send_ticks(input int n);
		repeat (n) send_item(CMD_TICK, 8'($urandom_range(0, 255)));
	endtask

	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 7))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// Receiver: random stalls per status word, plus one long hold-off on request.
	initial begin : receiver
		int gap;
		m_axis_tready <= 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				m_axis_tready <= 1'b0;
				repeat (400) @(posedge clk);
				hold_req = 1'b0;
			end
			gap = no_gaps ? 0 : $urandom_range(0, 6);
			if (gap > 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
		end
	end

	initial begin : stimulus
		int mode;
		int n;
		logic [7:0] fill [14];
		fill = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'hA5, 8'h5A, 8'h0F,
			8'hF0, 8'h33, 8'hCC, 8'h55, 8'hAA, 8'h7E, 8'h81};
		s_axis_tvalid <= 1'b0;
		s_axis_tuser <= CMD_ENQUEUE;
		s_axis_tdata <= 8'h00;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// tick with nothing queued changes nothing
		send_ticks(1);
		// fill the ring while idle with fourteen bytes and one more, then the next pushes out the oldest
		foreach (fill[i]) send_byte(fill[i]);
		send_byte(8'hC3);
		send_byte(8'h3C);
		// into the data phase with a full ring: the next byte is dropped
		send_ticks(3);
		send_byte(8'hE7);
		send_ticks(2);
		send_byte(8'h18);

		while (items_sent < 900) begin
			if (items_sent > 300 && items_sent < 320 && !hold_req) begin
				hold_req = 1'b1;
			end
			mode = $urandom_range(0, 9);
			if (mode <= 5) begin
				// well-formed: a burst of bytes, then ticks to send some of them
				n = $urandom_range(1, 18);
				repeat (n) send_byte(pick_byte());
				send_ticks($urandom_range(0, 60));
			end else if (mode <= 7) begin
				repeat (30) begin
					if ($urandom_range(0, 9) < 3)
						send_byte(pick_byte());
					else
						send_ticks(1);
				end
			end else if (mode == 8) begin
				send_ticks($urandom_range(20, 60));
			end else begin
				no_gaps = ~no_gaps;
			end
		end
		no_gaps = 1'b0;

		// drop valid right at the edge of the last transfer
		s_axis_tvalid <= 1'b0;
		while (outstanding != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatches == 0 && outstanding == 0) begin
			$display("tb_uart_tx_with_ring_fifo: clean");
		end else begin
			$display("tb_uart_tx_with_ring_fifo: errors");
		end
		$finish;
	end

	initial begin : watchdog
		#400000;
		$display("tb_uart_tx_with_ring_fifo: errors");
		$finish;
	end

endmodule

// ===== files.f =====
design/utxrf_pkg.sv
design/utxrf_ram.sv
design/uart_tx_with_ring_fifo.sv
tb/utxrf_checker.sv
tb/tb_uart_tx_with_ring_fifo.sv
